/* src/tlpw_pkg.sv */
`timescale 1ns / 1ps

package tlpw_pkg;

    // Field widths
    localparam int ACTION_W   = 2;
    localparam int ADDR_W     = 32;
    localparam int DATA_W     = 32;
    localparam int FAULT_W    = 2;
    localparam int ROOT_W     = 22;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 22;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_STORE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;

    // Fault codes
    localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_DIR  = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_LEAF = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATE_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PAGE_NUMBER = 1'd1;

    // Entry layout
    localparam int PAGE_SHIFT = 12;
    localparam int BIT_VALID  = 0;
    localparam int BIT_ACCESS = 6;
    localparam int BIT_DIRTY  = 7;
    localparam int PPN_LSB    = 10;

endpackage

/* src/tlpw_in_if.sv */
`timescale 1ns / 1ps

interface tlpw_in_if
    import tlpw_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   address;
    logic [DATA_W-1:0]   store_data;

    modport source (output valid, action, address, store_data, input ready);
    modport sink   (input valid, action, address, store_data, output ready);
endinterface

/* src/tlpw_out_if.sv */
`timescale 1ns / 1ps

interface tlpw_out_if
    import tlpw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  physical_address;
    logic [FAULT_W-1:0] fault_code;
    logic               entry_updated;

    modport source (output valid, physical_address, fault_code, entry_updated, input ready);
    modport sink   (input valid, physical_address, fault_code, entry_updated, output ready);
endinterface

/* src/two_level_page_walker.sv */
`timescale 1ns / 1ps
// Pass-through beats, and stores with their table write, go to the result register when it
// is free, else wait in S_DONE; a translation steps through S_DIR and S_LEAF (two dependent
// reads of the single-port table memory, leaf write-back folded into S_LEAF). A new beat is
// taken only in S_IDLE. With a non-power-of-two MEMORY_WORDS every table access passes
// through S_RED, then S_ACC (reciprocal multiply, remainder, then the access). A result
// held by the receiver stalls the input. Reset clears control and config registers; table
// contents are undefined until stored, and no clearing pass is run.

module two_level_page_walker
    import tlpw_pkg::*;
#(
    parameter int MEMORY_WORDS = 16384
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    tlpw_in_if.sink               req,
    tlpw_out_if.source            rsp
);

    localparam int  IDX_W     = $clog2(MEMORY_WORDS);
    localparam bit  POW2      = ((MEMORY_WORDS & (MEMORY_WORDS - 1)) == 0);
    localparam int  WADDR_W   = ADDR_W - 2;
    localparam int  RCNT_W    = 1;
    localparam int  RSH       = WADDR_W + IDX_W;
    localparam int  QUO_W     = WADDR_W - IDX_W + 1;
    localparam logic [IDX_W:0]    MEM_LIMIT = (IDX_W+1)'(MEMORY_WORDS);
    localparam logic [RCNT_W-1:0] RED_LAST  = RCNT_W'(1);
    // ceil(2^RSH / MEMORY_WORDS): exact quotient for any 30-bit word address
    localparam logic [WADDR_W:0]  RECIP     = (WADDR_W+1)'(((64'd1 << RSH)
                                              + 64'(MEMORY_WORDS) - 64'd1)
                                              / 64'(MEMORY_WORDS));

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RED  = 6'b000010,
        S_ACC  = 6'b000100,
        S_DIR  = 6'b001000,
        S_LEAF = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        K_STORE = 2'd0,
        K_DIR   = 2'd1,
        K_LEAF  = 2'd2
    } kind_t;

    // Control and config registers
    state_t              state_reg, state_next;
    logic                en_reg;
    logic [ROOT_W-1:0]   root_reg;
    kind_t               kind_reg, kind_next;
    logic                out_valid_reg, out_valid_next;

    // Item and datapath registers
    logic                wr_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [WADDR_W-1:0]  red_src_reg, red_src_next;
    logic [QUO_W-1:0]    red_quo_reg, red_quo_next;
    logic [IDX_W:0]      red_rem_reg, red_rem_next;
    logic [RCNT_W-1:0]   red_cnt_reg, red_cnt_next;
    logic [ADDR_W-1:0]   pend_phys_reg;
    logic [FAULT_W-1:0]  pend_fault_reg;
    logic                pend_upd_reg;
    logic [ADDR_W-1:0]   out_phys_reg;
    logic [FAULT_W-1:0]  out_fault_reg;
    logic                out_upd_reg;

    // Table memory
    logic [DATA_W-1:0]   mem [MEMORY_WORDS];
    logic [DATA_W-1:0]   mem_rdata;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_idx;
    logic [DATA_W-1:0]   mem_wdata;

    // Combinational control
    logic                in_fire;
    logic                out_free;
    logic                acc_req;
    kind_t               acc_req_kind;
    logic [ADDR_W-1:0]   acc_req_baddr;
    logic                acc_go;
    kind_t               acc_kind;
    logic                fin;
    logic [ADDR_W-1:0]   fin_phys;
    logic [FAULT_W-1:0]  fin_fault;
    logic                fin_upd;
    logic                load_out;
    logic                load_pend;
    logic [2*WADDR_W:0]  red_prod;
    logic [IDX_W:0]      red_qm;
    logic [DATA_W-1:0]   new_leaf;
    logic                need_upd;

    assign in_fire  = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid            = out_valid_reg;
    assign rsp.physical_address = out_phys_reg;
    assign rsp.fault_code       = out_fault_reg;
    assign rsp.entry_updated    = out_upd_reg;

    // Word-index reduction: quotient by reciprocal multiply, remainder from its low bits
    assign red_prod = (2*WADDR_W+1)'(red_src_reg) * (2*WADDR_W+1)'(RECIP);
    assign red_qm   = (IDX_W+1)'(red_quo_reg) * MEM_LIMIT;

    // Leaf A/D update
    assign need_upd = !mem_rdata[BIT_ACCESS] || (wr_reg && !mem_rdata[BIT_DIRTY]);
    always_comb
    begin
        new_leaf = mem_rdata;
        new_leaf[BIT_ACCESS] = 1'b1;
        if (wr_reg)
        begin
            new_leaf[BIT_DIRTY] = 1'b1;
        end
    end

    // Walk control
    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        red_src_next  = red_src_reg;
        red_quo_next  = red_quo_reg;
        red_rem_next  = red_rem_reg;
        red_cnt_next  = red_cnt_reg;
        acc_req       = 1'b0;
        acc_req_kind  = K_STORE;
        acc_req_baddr = '0;
        fin           = 1'b0;
        fin_phys      = '0;
        fin_fault     = FAULT_NONE;
        fin_upd       = 1'b0;
        mem_we        = 1'b0;
        mem_idx       = idx_reg;
        mem_wdata     = data_reg;
        load_out      = 1'b0;
        load_pend     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (req.action)
                        ACT_STORE:
                        begin
                            acc_req       = 1'b1;
                            acc_req_kind  = K_STORE;
                            acc_req_baddr = req.address;
                        end
                        ACT_READ, ACT_WRITE:
                        begin
                            if (en_reg)
                            begin
                                acc_req       = 1'b1;
                                acc_req_kind  = K_DIR;
                                acc_req_baddr = {root_reg[ADDR_W-PAGE_SHIFT-1:0],
                                                 PAGE_SHIFT'(0)}
                                              + {20'd0, req.address[31:22], 2'b00};
                            end
                            else
                            begin
                                fin      = 1'b1;
                                fin_phys = req.address;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_RED:
            begin
                red_cnt_next = red_cnt_reg - 1'b1;
                if (red_cnt_reg == RED_LAST)
                begin
                    red_quo_next = red_prod[RSH +: QUO_W];
                end
                else
                begin
                    red_rem_next = red_src_reg[IDX_W:0] - red_qm;
                    state_next   = S_ACC;
                end
            end
            S_DIR:
            begin
                if (!mem_rdata[BIT_VALID])
                begin
                    fin       = 1'b1;
                    fin_fault = FAULT_DIR;
                end
                else
                begin
                    acc_req       = 1'b1;
                    acc_req_kind  = K_LEAF;
                    acc_req_baddr = {mem_rdata[PPN_LSB+ADDR_W-PAGE_SHIFT-1:PPN_LSB],
                                     PAGE_SHIFT'(0)}
                                  + {20'd0, addr_reg[21:12], 2'b00};
                end
            end
            S_LEAF:
            begin
                fin = 1'b1;
                if (!mem_rdata[BIT_VALID])
                begin
                    fin_fault = FAULT_LEAF;
                end
                else
                begin
                    fin_phys = {mem_rdata[PPN_LSB+ADDR_W-PAGE_SHIFT-1:PPN_LSB],
                                addr_reg[PAGE_SHIFT-1:0]};
                    if (need_upd)
                    begin
                        mem_we    = 1'b1;
                        mem_idx   = idx_reg;
                        mem_wdata = new_leaf;
                        fin_upd   = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Table access: now when the index is a plain bit-select, else after reduction
        if (acc_req && !POW2)
        begin
            kind_next    = acc_req_kind;
            red_src_next = acc_req_baddr[ADDR_W-1:2];
            red_rem_next = '0;
            red_cnt_next = RED_LAST;
            state_next   = S_RED;
        end
        acc_go   = (acc_req && POW2) || (state_reg == S_ACC);
        acc_kind = (state_reg == S_ACC) ? kind_reg : acc_req_kind;
        if (acc_go)
        begin
            mem_idx = (state_reg == S_ACC) ? red_rem_reg[IDX_W-1:0]
                                           : acc_req_baddr[IDX_W+1:2];
            case (acc_kind)
                K_STORE:
                begin
                    mem_we    = 1'b1;
                    mem_wdata = (state_reg == S_ACC) ? data_reg : req.store_data;
                    fin       = 1'b1;
                end
                K_DIR:
                begin
                    state_next = S_DIR;
                end
                K_LEAF:
                begin
                    state_next = S_LEAF;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end

        // Finished result goes straight out, or waits behind the busy result
        if (fin)
        begin
            if (out_free)
            begin
                load_out   = 1'b1;
                state_next = S_IDLE;
            end
            else
            begin
                load_pend  = 1'b1;
                state_next = S_DONE;
            end
        end

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= K_STORE;
            out_valid_reg <= 1'b0;
            en_reg        <= 1'b0;
            root_reg      <= '0;
            red_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
            red_cnt_reg   <= red_cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TRANSLATE_ENABLE: en_reg   <= cfg_wdata[0];
                    CFG_ROOT_PAGE_NUMBER: root_reg <= cfg_wdata[ROOT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        red_src_reg <= red_src_next;
        red_quo_reg <= red_quo_next;
        red_rem_reg <= red_rem_next;
        if (in_fire)
        begin
            wr_reg   <= (req.action == ACT_WRITE);
            addr_reg <= req.address;
            data_reg <= req.store_data;
        end
        if (acc_go)
        begin
            idx_reg <= mem_idx;
        end
        if (load_pend)
        begin
            pend_phys_reg  <= fin_phys;
            pend_fault_reg <= fin_fault;
            pend_upd_reg   <= fin_upd;
        end
        if (load_out)
        begin
            out_phys_reg  <= (state_reg == S_DONE) ? pend_phys_reg  : fin_phys;
            out_fault_reg <= (state_reg == S_DONE) ? pend_fault_reg : fin_fault;
            out_upd_reg   <= (state_reg == S_DONE) ? pend_upd_reg   : fin_upd;
        end
    end

    // Single-port table memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_idx] <= mem_wdata;
        end
        mem_rdata <= mem[mem_idx];
    end

    // Checks
    a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_IDLE || state_reg == S_ACC || state_reg == S_LEAF))
        else $error("table write outside a store or leaf write-back");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> rsp.valid)
        else $error("result parked while output register is empty");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.fault_code != FAULT_NONE) |->
            (rsp.physical_address == '0 && !rsp.entry_updated))
        else $error("faulting result carries an address or an update");

    a_leaf_after_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEAF) |-> ($past(state_reg) == S_DIR || $past(state_reg) == S_ACC))
        else $error("leaf stage entered without a preceding table read");

endmodule

/* verif/two_level_page_walker_test.sv */
`timescale 1ns / 1ps

module two_level_page_walker_test;
    import tlpw_pkg::*;

    localparam int MEMORY_WORDS = 16384;
    // Action code three does nothing; its result is all zero
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   store_data;
    } walk_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  phys;
        logic [FAULT_W-1:0] fault;
        logic               updated;
    } walk_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    tlpw_in_if  req_if ();
    tlpw_out_if rsp_if ();

    two_level_page_walker #(
        .MEMORY_WORDS(MEMORY_WORDS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    always #4 clk = ~clk;

    // Shadow of the table memory and the configuration
    logic [31:0]       shadow_mem [MEMORY_WORDS];
    bit                shadow_written [MEMORY_WORDS];
    logic              xlate_on;
    logic [ROOT_W-1:0] root_ppn;

    walk_res_t expected_translations [$];
    int        fail_count = 0;
    int        burst_left = 0;
    int        rsp_hold_req = 0;

    // Address pools so that walks hit the same entries again
    logic [9:0]        vpn1_pool [4];
    logic [9:0]        vpn0_pool [8];
    logic [ROOT_W-1:0] leaf_page_pool [8];

    function automatic int word_of(input logic [31:0] byte_addr);
        return int'((byte_addr >> 2) % MEMORY_WORDS);
    endfunction

    function automatic int dir_word_of(input logic [31:0] va);
        return word_of((32'(root_ppn) << PAGE_SHIFT) + 32'(va[31:22]) * 4);
    endfunction

    function automatic int leaf_word_of(input logic [31:0] dir_e, input logic [31:0] va);
        return word_of((32'(dir_e[31:PPN_LSB]) << PAGE_SHIFT) + 32'(va[21:12]) * 4);
    endfunction

    function automatic logic [31:0] entry_of(input logic [ROOT_W-1:0] ppn, input logic v,
                                             input logic a, input logic d);
        logic [31:0] e;
        e = $urandom();
        e[31:PPN_LSB]  = ppn;
        e[BIT_VALID]   = v;
        e[BIT_ACCESS]  = a;
        e[BIT_DIRTY]   = d;
        return e;
    endfunction

    function automatic logic [31:0] random_entry(input logic [ROOT_W-1:0] ppn,
                                                 input int valid_pct);
        return entry_of(ppn, $urandom_range(99) < valid_pct, 1'($urandom_range(1)),
                        1'($urandom_range(1)));
    endfunction

    function automatic logic [31:0] pick_vaddr();
        return {vpn1_pool[$urandom_range(3)], vpn0_pool[$urandom_range(7)],
                12'($urandom())};
    endfunction

    // Expected result of one beat; updates the shadow memory as the walker would
    function automatic walk_res_t predict_translation(input walk_req_t item);
        walk_res_t   r;
        int          di;
        int          li;
        logic [31:0] dir_e;
        logic [31:0] leaf_e;
        logic        wr;
        r  = '0;
        wr = (item.action == ACT_WRITE);
        case (item.action)
            ACT_STORE:
            begin
                shadow_mem[word_of(item.address)]     = item.store_data;
                shadow_written[word_of(item.address)] = 1'b1;
            end
            ACT_READ, ACT_WRITE:
            begin
                if (!xlate_on)
                    r.phys = item.address;
                else
                begin
                    di    = dir_word_of(item.address);
                    dir_e = shadow_mem[di];
                    if (!dir_e[BIT_VALID])
                        r.fault = FAULT_DIR;
                    else
                    begin
                        li     = leaf_word_of(dir_e, item.address);
                        leaf_e = shadow_mem[li];
                        if (!leaf_e[BIT_VALID])
                            r.fault = FAULT_LEAF;
                        else
                        begin
                            // A/D write-back
                            if (!leaf_e[BIT_ACCESS] || (wr && !leaf_e[BIT_DIRTY]))
                            begin
                                leaf_e[BIT_ACCESS] = 1'b1;
                                if (wr)
                                    leaf_e[BIT_DIRTY] = 1'b1;
                                shadow_mem[li] = leaf_e;
                                r.updated      = 1'b1;
                            end
                            r.phys = (32'(leaf_e[31:PPN_LSB]) << PAGE_SHIFT)
                                   | {20'b0, item.address[11:0]};
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Send one beat; the sender works in bursts with random gaps
    task automatic send_beat(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
        walk_req_t item;
        int        gap;
        item.action     = act;
        item.address    = addr;
        item.store_data = data;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        expected_translations.push_back(predict_translation(item));
        req_if.valid      <= 1'b1;
        req_if.action     <= act;
        req_if.address    <= addr;
        req_if.store_data <= data;
        do @(posedge clk); while (req_if.ready !== 1'b1);
    endtask

    // Store a table word; upper address bits and the low two bits are don't-care
    task automatic store_word(input int idx, input logic [31:0] data);
        logic [31:0] addr;
        addr = $urandom();
        addr = (addr & ~32'(MEMORY_WORDS * 4 - 1)) | (32'(idx) << 2)
             | 32'($urandom_range(3));
        send_beat(ACT_STORE, addr, data);
    endtask

    task automatic map_page(input logic [31:0] va, input logic [31:0] dir_e,
                            input logic [31:0] leaf_e);
        store_word(dir_word_of(va), dir_e);
        store_word(leaf_word_of(dir_e, va), leaf_e);
    endtask

    // Translate, first storing any table word the walk would read unwritten
    task automatic walk(input logic [ACTION_W-1:0] act, input logic [31:0] va);
        int di;
        int li;
        if (xlate_on)
        begin
            di = dir_word_of(va);
            if (!shadow_written[di])
                store_word(di, random_entry(leaf_page_pool[$urandom_range(7)], 85));
            if (shadow_mem[di][BIT_VALID])
            begin
                li = leaf_word_of(shadow_mem[di], va);
                if (!shadow_written[li])
                    store_word(li, random_entry(22'($urandom()), 85));
            end
        end
        send_beat(act, va, $urandom());
    endtask

    // Replace the directory or leaf entry that an address uses
    task automatic rewrite_entry(input logic [31:0] va);
        int di;
        di = dir_word_of(va);
        if (!shadow_written[di] || !shadow_mem[di][BIT_VALID] || $urandom_range(3) == 0)
            store_word(di, random_entry(leaf_page_pool[$urandom_range(7)], 85));
        else
            store_word(leaf_word_of(shadow_mem[di], va), random_entry(22'($urandom()), 90));
    endtask

    // Hold the input idle until every result is back, then let the pipe settle
    task automatic drain_translations();
        req_if.valid <= 1'b0;
        while (expected_translations.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(input logic en, input logic [ROOT_W-1:0] root);
        drain_translations();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TRANSLATE_ENABLE;
        cfg_wdata <= CFG_DATA_W'(en);
        @(posedge clk);
        cfg_index <= CFG_ROOT_PAGE_NUMBER;
        cfg_wdata <= root;
        @(posedge clk);
        cfg_we   <= 1'b0;
        xlate_on = en;
        root_ppn = root;
    endtask

    // Translation off: addresses pass through, stores and unused action give zero
    task automatic test_passthrough();
        set_config(1'b0, '0);
        send_beat(ACT_READ, 32'h0000_0000, 32'hFFFF_FFFF);
        send_beat(ACT_WRITE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_beat(ACT_READ, $urandom(), $urandom());
        send_beat(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(ACT_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Basic walks: A/D update on first touch, faults on invalid entries
    task automatic test_walk_basic();
        set_config(1'b1, '0);
        map_page(32'h0000_0000, entry_of(22'd5, 1'b1, 1'b0, 1'b0),
                 entry_of(22'h3F_FFFF, 1'b1, 1'b0, 1'b0));
        send_beat(ACT_READ, 32'h0000_0000, $urandom());
        send_beat(ACT_READ, 32'h0000_0ABC, $urandom());
        send_beat(ACT_WRITE, 32'h0000_0FFF, $urandom());
        send_beat(ACT_WRITE, 32'h0000_0123, $urandom());
        map_page(32'hFFFF_FFFF, entry_of(22'd6, 1'b1, 1'b1, 1'b1),
                 entry_of(22'h1_2345, 1'b1, 1'b1, 1'b0));
        send_beat(ACT_WRITE, 32'hFFFF_FFFF, $urandom());
        map_page(32'h0040_0000, entry_of(22'd9, 1'b0, 1'b1, 1'b1),
                 entry_of(22'h0, 1'b1, 1'b0, 1'b0));
        send_beat(ACT_READ, 32'h0040_0000, $urandom());
        map_page(32'h0080_1000, entry_of(22'd7, 1'b1, 1'b0, 1'b0),
                 entry_of(22'h3_0000, 1'b0, 1'b0, 1'b0));
        send_beat(ACT_WRITE, 32'h0080_1000, $urandom());
        send_beat(ACT_UNUSED, $urandom(), $urandom());
    endtask

    // Largest and random root page numbers; table addresses wrap
    task automatic test_root_extremes();
        set_config(1'b1, 22'h3F_FFFF);
        map_page(32'h1234_5678, entry_of(22'd3, 1'b1, 1'b0, 1'b0),
                 entry_of(22'($urandom()), 1'b1, 1'b0, 1'b0));
        send_beat(ACT_READ, 32'h1234_5678, $urandom());
        set_config(1'b1, 22'($urandom()));
        walk(ACT_WRITE, pick_vaddr());
        walk(ACT_READ, $urandom());
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering beats
    task automatic test_backpressure();
        set_config(1'b1, 22'($urandom()));
        rsp_hold_req = 400;
        burst_left   = 100;
        repeat (60)
            walk($urandom_range(1) ? ACT_WRITE : ACT_READ, pick_vaddr());
        drain_translations();
    endtask

    task automatic test_random_traffic();
        int          k;
        logic        en;
        logic [21:0] root;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       begin en = 1'b0; root = 22'($urandom()); end
                1:       begin en = 1'b1; root = '0;              end
                2:       begin en = 1'b1; root = 22'h3F_FFFF;     end
                default: begin en = ($urandom_range(4) != 0); root = 22'($urandom()); end
            endcase
            set_config(en, root);
            // Sometimes a long stretch with no sender gaps
            if ($urandom_range(3) == 0)
                burst_left = 150;
            repeat (100)
            begin
                k = $urandom_range(99);
                if (k < 50)
                    walk($urandom_range(1) ? ACT_WRITE : ACT_READ, pick_vaddr());
                else if (k < 62)
                    walk($urandom_range(1) ? ACT_WRITE : ACT_READ, $urandom());
                else if (k < 75)
                    rewrite_entry(pick_vaddr());
                else if (k < 87)
                    send_beat(ACT_STORE, $urandom(), $urandom());
                else if (k < 92)
                    send_beat(ACT_UNUSED, $urandom(), $urandom());
                else
                    walk(ACT_READ, pick_vaddr());
            end
        end
    endtask

    // Receiver stall pattern: phases of varying stall rate, plus requested hold-offs
    initial
    begin : rsp_ready_gen
        int phase_left;
        int stall_pct;
        int held;
        rsp_if.ready = 1'b0;
        phase_left   = 0;
        stall_pct    = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_req > 0)
            begin
                held         = rsp_hold_req;
                rsp_hold_req = 0;
                rsp_if.ready <= 1'b0;
                repeat (held) @(posedge clk);
            end
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(20, 200);
                case ($urandom_range(3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 80;
                endcase
            end
            phase_left--;
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : result_check
        walk_res_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (expected_translations.size() == 0)
            begin
                $error("result beat with nothing expected: physical_address %h",
                       rsp_if.physical_address);
                fail_count++;
            end
            else
            begin
                want = expected_translations.pop_front();
                if (rsp_if.physical_address !== want.phys)
                begin
                    $error("physical_address: expected %h, actual %h", want.phys,
                           rsp_if.physical_address);
                    fail_count++;
                end
                if (rsp_if.fault_code !== want.fault)
                begin
                    $error("fault_code: expected %0d, actual %0d", want.fault,
                           rsp_if.fault_code);
                    fail_count++;
                end
                if (rsp_if.entry_updated !== want.updated)
                begin
                    $error("entry_updated: expected %0b, actual %0b", want.updated,
                           rsp_if.entry_updated);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : main_seq
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        req_if.valid      = 1'b0;
        req_if.action     = '0;
        req_if.address    = '0;
        req_if.store_data = '0;
        xlate_on          = 1'b0;
        root_ppn          = '0;
        vpn1_pool = '{10'd0, 10'd1023, 10'($urandom()), 10'($urandom())};
        vpn0_pool[0] = 10'd0;
        vpn0_pool[1] = 10'd1023;
        for (int i = 2; i < 8; i++)
            vpn0_pool[i] = 10'($urandom());
        leaf_page_pool[0] = '0;
        leaf_page_pool[1] = 22'h3F_FFFF;
        for (int i = 2; i < 8; i++)
            leaf_page_pool[i] = 22'($urandom());

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough();
        test_walk_basic();
        test_root_extremes();
        test_backpressure();
        test_random_traffic();

        drain_translations();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && expected_translations.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
